>>> hw/rtl/serial_midi_to_usb_midi_packetizer_assert.svh
// assertion macros shared by the packetizer rtl
`ifndef SERIAL_MIDI_TO_USB_MIDI_PACKETIZER_ASSERT_SVH
`define SERIAL_MIDI_TO_USB_MIDI_PACKETIZER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define SMUP_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define SMUP_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/smup_pkg.sv
// types and constants of the serial midi to usb-midi packetizer
`default_nettype none

package smup_pkg;

  localparam logic [7:0] REALTIME_MIN = 8'hF8;
  localparam logic [7:0] SYSEX_START  = 8'hF0;
  localparam logic [7:0] SYSEX_END    = 8'hF7;
  localparam logic [7:0] STATUS_MIN   = 8'h80;
  localparam logic [3:0] CIN_SYSEX    = 4'h4;
  localparam logic [3:0] CIN_REALTIME = 4'hF;

  typedef struct packed {
    logic [3:0] code_index;
    logic [7:0] byte1;
    logic [7:0] byte2;
    logic [7:0] byte3;
  } packet_t;

  // message length from the status high nibble
  function automatic logic [1:0] length_of_status(input logic [7:0] status);
    logic [1:0] len;
    case (status[7:4])
      4'h8, 4'h9, 4'hA, 4'hB, 4'hE: len = 2'd3;
      4'hC, 4'hD: len = 2'd2;
      4'hF: len = 2'd1;
      default: len = 2'd0;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/smup_parse_core.sv
// parser state and per-byte packet assembly
`default_nettype none
`include "serial_midi_to_usb_midi_packetizer_assert.svh"

module smup_parse_core
  import smup_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       step,
  input  wire logic [7:0] midi_byte,
  output logic            pkt_valid,
  output packet_t         pkt
);

  logic       in_sysex;
  logic [1:0] byte_position;
  logic [1:0] expected_length;
  logic [7:0] held [3];

  logic       in_sysex_next;
  logic [1:0] byte_position_next;
  logic [1:0] expected_length_next;
  logic [7:0] held_next [3];

  logic       is_rt;
  logic       is_status;
  logic       is_start;
  logic       is_end;
  logic       is_stray;
  logic       sx_a;
  logic [1:0] pos_a;
  logic [1:0] pos_b;

  assign is_rt     = midi_byte >= REALTIME_MIN;
  assign is_status = midi_byte >= STATUS_MIN;
  assign is_start  = midi_byte == SYSEX_START;
  assign is_end    = midi_byte == SYSEX_END;
  assign is_stray  = !is_status && byte_position == 2'd0 && !in_sysex;

  // sysex flag and position after the status handling, before the byte is held
  assign sx_a  = is_start ? 1'b1 : (is_end ? 1'b0 : in_sysex);
  assign pos_a = (is_status && !is_end) ? 2'd0 : byte_position;
  assign pos_b = (pos_a == 2'd3) ? 2'd3 : 2'(pos_a + 2'd1);

  always_comb begin
    in_sysex_next        = in_sysex;
    byte_position_next   = byte_position;
    expected_length_next = expected_length;
    held_next            = held;
    pkt_valid            = 1'b0;
    if (step) begin
      if (is_rt) begin
        held_next[0]       = midi_byte;
        held_next[1]       = 8'h00;
        held_next[2]       = 8'h00;
        byte_position_next = 2'd0;
        pkt_valid          = 1'b1;
      end else if (!is_stray) begin
        in_sysex_next      = sx_a;
        byte_position_next = pos_b;
        if (is_status && !is_start && !is_end) begin
          expected_length_next = length_of_status(midi_byte);
        end
        if (pos_a != 2'd3) begin
          held_next[pos_a] = midi_byte;
        end
        if (sx_a) begin
          if (pos_b == 2'd3) begin
            pkt_valid          = 1'b1;
            byte_position_next = 2'd0;
          end
        end else if (is_end) begin
          pkt_valid          = 1'b1;
          byte_position_next = 2'd0;
        end else if (pos_b == expected_length_next) begin
          pkt_valid          = 1'b1;
          // status stays held for running status
          byte_position_next = 2'd1;
        end
        // unused packet bytes are cleared and stay cleared
        if (pkt_valid && !sx_a) begin
          for (int i = 0; i < 3; i++) begin
            if (2'(i) >= pos_b) begin
              held_next[i] = 8'h00;
            end
          end
        end
      end
    end
  end

  always_comb begin
    pkt.byte1 = held_next[0];
    pkt.byte2 = held_next[1];
    pkt.byte3 = held_next[2];
    if (is_rt) begin
      pkt.code_index = CIN_REALTIME;
    end else if (sx_a) begin
      pkt.code_index = CIN_SYSEX;
    end else if (is_end) begin
      pkt.code_index = CIN_SYSEX + {2'b00, pos_b};
    end else begin
      pkt.code_index = held_next[0][7:4];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_sysex        <= 1'b0;
      byte_position   <= 2'd0;
      expected_length <= 2'd0;
      held[0]         <= 8'h00;
      held[1]         <= 8'h00;
      held[2]         <= 8'h00;
    end else begin
      in_sysex        <= in_sysex_next;
      byte_position   <= byte_position_next;
      expected_length <= expected_length_next;
      held            <= held_next;
    end
  end

  `SMUP_ASSERT_NXT(a_rt_clears_pos, clk, rst, step && is_rt, byte_position == 2'd0, "real-time byte left a byte position")
  `SMUP_ASSERT_NXT(a_start_opens_sysex, clk, rst, step && is_start, in_sysex, "sysex start did not open sysex")
  `SMUP_ASSERT_IMP(a_stray_no_packet, clk, rst, step && is_stray, !pkt_valid, "stray data byte made a packet")

endmodule

`default_nettype wire

>>> hw/rtl/serial_midi_to_usb_midi_packetizer.sv
// serial midi byte stream to usb-midi event packet converter, top level
// input channel: one serial midi byte per request on midi_byte, with in_valid
//   and in_stall; a byte is taken at a clock edge with in_valid high and
//   in_stall low
// output channel: one usb-midi event packet per request (code_index on cable
//   zero plus packet_byte1..3, unused bytes zero), with out_valid and out_stall
// a byte makes zero or one packet: real-time bytes pass at once, channel and
//   system common messages come out when complete with running status kept,
//   sysex goes out in groups of three and is closed by f7
// a byte sits in the input register until the parse step runs, where it is
//   parsed against the running state and lands in the output register
// throughput: one byte per cycle while out_stall does not hold the output
//   register, set by the single parse step between the input and output registers
// reset (rst, synchronous): clears the valid flags of both registers, the sysex
//   flag, the byte position, the expected length and the held bytes
// out_stall holds a valid output register; a byte in the input register then
//   waits and in_stall rises, so one byte and one packet are held meanwhile
`default_nettype none
`include "serial_midi_to_usb_midi_packetizer_assert.svh"

module serial_midi_to_usb_midi_packetizer
  import smup_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] midi_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [3:0]      code_index,
  output logic [7:0]      packet_byte1,
  output logic [7:0]      packet_byte2,
  output logic [7:0]      packet_byte3
);

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       advance;
  logic       pkt_valid;
  packet_t    pkt;
  packet_t    out_pkt;

  // the parse step runs whenever the output register can take its result
  assign advance  = !out_valid || !out_stall;
  assign in_stall = s1_valid && !advance;

  smup_parse_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (s1_valid && advance),
    .midi_byte (s1_byte),
    .pkt_valid (pkt_valid),
    .pkt       (pkt)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte <= midi_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid && pkt_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid && pkt_valid) begin
      out_pkt <= pkt;
    end
  end

  assign code_index   = out_pkt.code_index;
  assign packet_byte1 = out_pkt.byte1;
  assign packet_byte2 = out_pkt.byte2;
  assign packet_byte3 = out_pkt.byte3;

  `SMUP_ASSERT_IMP(a_stall_needs_held_byte, clk, rst, in_stall, s1_valid && out_valid, "empty stall")

endmodule

`default_nettype wire

>>> sim/midi_packet_monitor.sv
// predicts and checks usb-midi event packets from the observed serial midi byte requests
`timescale 1ns / 100ps

module midi_packet_monitor
  import smup_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] midi_byte,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [3:0] code_index,
  input  logic [7:0] packet_byte1,
  input  logic [7:0] packet_byte2,
  input  logic [7:0] packet_byte3,
  output int         fail_count,
  output int         pending
);

  // parser state as the block should hold it
  logic       sysex_open;
  logic [1:0] byte_pos;
  logic [1:0] msg_len;
  logic [7:0] held [3];

  packet_t expected_packets [$];

  initial begin
    fail_count = 0;
    pending = 0;
  end

  function automatic logic [1:0] message_length(input logic [7:0] status);
    logic [1:0] len;
    case (status[7:4])
      4'h8, 4'h9, 4'hA, 4'hB, 4'hE: len = 2'd3;
      4'hC, 4'hD: len = 2'd2;
      4'hF: len = 2'd1;
      default: len = 2'd0;
    endcase
    return len;
  endfunction

  // unused held bytes are cleared in the state too, not just in the packet
  task push_packet(input logic [3:0] code, input logic [1:0] count);
    packet_t pkt;
    for (int i = count; i < 3; i++) held[i] = 8'h00;
    pkt.code_index = code;
    pkt.byte1 = held[0];
    pkt.byte2 = held[1];
    pkt.byte3 = held[2];
    expected_packets.push_back(pkt);
    pending = pending + 1;
  endtask

  task predict_byte(input logic [7:0] b);
    logic take;
    take = 1'b1;
    if (b >= REALTIME_MIN) begin
      held[0] = b;
      push_packet(CIN_REALTIME, 2'd1);
      byte_pos = 2'd0;
    end else begin
      if (b == SYSEX_START) begin
        sysex_open = 1'b1;
        byte_pos = 2'd0;
      end else if (b == SYSEX_END) begin
        sysex_open = 1'b0;
      end else if (b >= STATUS_MIN) begin
        byte_pos = 2'd0;
        msg_len = message_length(b);
      end else if (byte_pos == 2'd0 && !sysex_open) begin
        take = 1'b0;
      end
      if (take) begin
        // saturates: a fourth byte is dropped
        if (byte_pos < 2'd3) begin
          held[byte_pos] = b;
          byte_pos = byte_pos + 2'd1;
        end
        if (sysex_open) begin
          if (byte_pos == 2'd3) begin
            push_packet(CIN_SYSEX, 2'd3);
            byte_pos = 2'd0;
          end
        end else if (b == SYSEX_END) begin
          push_packet(CIN_SYSEX + {2'b00, byte_pos}, byte_pos);
          byte_pos = 2'd0;
        end else if (byte_pos == msg_len) begin
          push_packet(held[0][7:4], byte_pos);
          // keep status for running status
          byte_pos = 2'd1;
        end
      end
    end
  endtask

  task check_field(input string name, input logic [7:0] exp_val, input logic [7:0] act_val);
    if (act_val !== exp_val) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_val, act_val);
      fail_count = fail_count + 1;
    end
  endtask

  always @(posedge clk) begin
    packet_t exp_pkt;
    if (rst) begin
      sysex_open = 1'b0;
      byte_pos = 2'd0;
      msg_len = 2'd0;
      held[0] = 8'h00;
      held[1] = 8'h00;
      held[2] = 8'h00;
      expected_packets.delete();
      pending = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_packets.size() == 0) begin
          $display("%0t: unexpected packet: expected none, actual %h %h %h %h", $time,
                   code_index, packet_byte1, packet_byte2, packet_byte3);
          fail_count = fail_count + 1;
        end else begin
          exp_pkt = expected_packets.pop_front();
          pending = pending - 1;
          check_field("code_index", {4'h0, exp_pkt.code_index}, {4'h0, code_index});
          check_field("packet_byte1", exp_pkt.byte1, packet_byte1);
          check_field("packet_byte2", exp_pkt.byte2, packet_byte2);
          check_field("packet_byte3", exp_pkt.byte3, packet_byte3);
        end
      end
      if (in_valid && !in_stall) predict_byte(midi_byte);
    end
  end

endmodule

>>> sim/tb_serial_midi_to_usb_midi_packetizer.sv
// stimulus, clocking and verdict for the serial midi to usb-midi packetizer
`timescale 1ns / 100ps

module tb_serial_midi_to_usb_midi_packetizer;

  localparam int RANDOM_ITEMS = 650;
  localparam int STALL_PCT = 11;
  localparam int unsigned CYCLE_LIMIT = 100000;

  logic       clk;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] midi_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [3:0] code_index;
  logic [7:0] packet_byte1;
  logic [7:0] packet_byte2;
  logic [7:0] packet_byte3;

  int fail_count;
  int pending;
  int bytes_sent = 0;
  int unsigned cycle_count = 0;
  logic quiet_stretch = 1'b0;

  // extremes, running status, full position, status and real-time inside sysex, stray f7
  logic [7:0] directed_seq [25] = '{
    8'h00, 8'h7F, 8'hFF, 8'hF8, 8'h90, 8'h00, 8'h7F, 8'h7F, 8'h00, 8'hC5,
    8'h12, 8'hF1, 8'h55, 8'h2A, 8'h01, 8'hF7, 8'hF0, 8'h01, 8'h02, 8'h03,
    8'h80, 8'hFE, 8'hF7, 8'hF7, 8'hE0
  };

  serial_midi_to_usb_midi_packetizer dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .midi_byte    (midi_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .code_index   (code_index),
    .packet_byte1 (packet_byte1),
    .packet_byte2 (packet_byte2),
    .packet_byte3 (packet_byte3)
  );

  midi_packet_monitor monitor (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .midi_byte    (midi_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .code_index   (code_index),
    .packet_byte1 (packet_byte1),
    .packet_byte2 (packet_byte2),
    .packet_byte3 (packet_byte3),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // receiver stalls at random outside the quiet stretch
  always @(negedge clk) begin
    out_stall = !quiet_stretch && ($urandom_range(0, 99) < STALL_PCT);
  end

  // one byte request, called at a falling edge, returns at a falling edge
  task send_midi_byte(input logic [7:0] b);
    quiet_stretch = (bytes_sent >= 250 && bytes_sent < 400);
    while (!quiet_stretch && $urandom_range(0, 99) < STALL_PCT) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    midi_byte = b;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    bytes_sent = bytes_sent + 1;
  endtask

  initial begin
    int kind;
    int n;
    int groups;
    logic [7:0] status;
    logic have_status;
    have_status = 1'b0;
    status = 8'h90;
    repeat (7) @(negedge clk);
    rst = 1'b0;

    foreach (directed_seq[i]) send_midi_byte(directed_seq[i]);

    while (bytes_sent < RANDOM_ITEMS + 25) begin
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        // channel message, sometimes on running status
        if (!have_status || $urandom_range(0, 3) != 0) begin
          status = {4'($urandom_range(8, 14)), 4'($urandom_range(0, 15))};
          send_midi_byte(status);
          have_status = 1'b1;
        end
        groups = $urandom_range(1, 3);
        repeat (groups) begin
          n = (status[7:4] == 4'hC || status[7:4] == 4'hD) ? 1 : 2;
          repeat (n) send_midi_byte(8'($urandom_range(0, 127)));
        end
      end else if (kind < 60) begin
        send_midi_byte(8'hF0);
        n = $urandom_range(0, 10);
        repeat (n) begin
          if ($urandom_range(0, 19) == 0) send_midi_byte(8'($urandom_range(8'hF8, 8'hFF)));
          else send_midi_byte(8'($urandom_range(0, 127)));
        end
        if ($urandom_range(0, 9) != 0) send_midi_byte(8'hF7);
        have_status = 1'b0;
      end else if (kind < 70) begin
        send_midi_byte(8'($urandom_range(8'hF1, 8'hF6)));
        n = $urandom_range(0, 3);
        repeat (n) send_midi_byte(8'($urandom_range(0, 127)));
        have_status = 1'b0;
      end else if (kind < 80) begin
        send_midi_byte(8'($urandom_range(8'hF8, 8'hFF)));
      end else begin
        send_midi_byte(8'($urandom_range(0, 255)));
        have_status = 1'b0;
      end
    end
    in_valid = 1'b0;

    wait (pending == 0);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
